// ----- src/ctqap_pkg.sv -----
// ctqap_pkg: shared types and constants of the can tx queue with aging and pacing
// used by ctqap_ctrl, ctqap_dp and the top level; no dependencies
`default_nettype none

package ctqap_pkg;

	localparam int ACTION_W   = 3;
	localparam int TIME_W     = 32;
	localparam int ID_W       = 11;
	localparam int LEN_W      = 4;
	localparam int PAYLOAD_W  = 64;
	localparam int STATUS_W   = 3;
	localparam int COUNT_W    = 4;
	localparam int LINK_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int IN_DATA_W  = 112;
	localparam int OUT_DATA_W = 88;

	localparam logic [LEN_W-1:0] MAX_LEN = 4'd8;

	localparam logic [TIME_W-1:0] LIFETIME_RST   = 32'd1000;
	localparam logic [TIME_W-1:0] PACING_GAP_RST = 32'd100;
	localparam logic              PACING_EN_RST  = 1'b1;

	typedef enum logic [ACTION_W-1:0] {
		ACT_ENQUEUE   = 3'd0,
		ACT_POLL      = 3'd1,
		ACT_TX_DONE   = 3'd2,
		ACT_BUS_ERROR = 3'd3,
		ACT_RX_FRAME  = 3'd4
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_NONE      = 3'd0,
		ST_QUEUED    = 3'd1,
		ST_OVERWROTE = 3'd2,
		ST_ISSUED    = 3'd3,
		ST_EXPIRED   = 3'd4,
		ST_PACING    = 3'd5,
		ST_BLOCKED   = 3'd6,
		ST_COMPLETED = 3'd7
	} status_t;

	typedef enum logic [LINK_W-1:0] {
		LINK_IDLE    = 2'd0,
		LINK_SENDING = 2'd1,
		LINK_ERROR   = 2'd2
	} link_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LIFETIME   = 2'd0,
		CFG_PACING_GAP = 2'd1,
		CFG_PACING_EN  = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [TIME_W-1:0]    stamp;
		logic [PAYLOAD_W-1:0] payload;
		logic [ID_W-1:0]      id;
		logic [LEN_W-1:0]     len;
	} slot_t;

	typedef struct packed {
		logic capture;
		logic commit;
	} dp_cmd_t;

endpackage

`default_nettype wire

// ----- src/ctqap_ctrl.sv -----
// ctqap_ctrl: sequencing of one item at a time, capture then evaluate and commit
// depends on ctqap_pkg
`default_nettype none

module ctqap_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output ctqap_pkg::dp_cmd_t     cmd
);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   commit;

	assign in_ready    = (state_q == S_IDLE);
	assign commit      = (state_q == S_EXEC) && (!out_valid_q || out_ready);
	assign cmd.capture = in_valid && in_ready;
	assign cmd.commit  = commit;
	assign out_valid   = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (commit) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- src/ctqap_dp.sv -----
// ctqap_dp: slot memory, ring indices, link state, time compares and result register
// depends on ctqap_pkg; driven by ctqap_ctrl commands
`default_nettype none

module ctqap_dp #(
	parameter int QUEUE_SLOTS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire ctqap_pkg::dp_cmd_t                  cmd,
	input  wire logic                                cfg_we,
	input  wire logic [ctqap_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [ctqap_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic [ctqap_pkg::ACTION_W-1:0]      action,
	input  wire logic [ctqap_pkg::TIME_W-1:0]        now_ms,
	input  wire logic [ctqap_pkg::ID_W-1:0]          msg_id,
	input  wire logic [ctqap_pkg::LEN_W-1:0]         msg_len,
	input  wire logic [ctqap_pkg::PAYLOAD_W-1:0]     msg_payload,
	output logic [ctqap_pkg::STATUS_W-1:0]           status,
	output logic [ctqap_pkg::ID_W-1:0]               frame_id,
	output logic [ctqap_pkg::LEN_W-1:0]              frame_len,
	output logic [ctqap_pkg::PAYLOAD_W-1:0]          frame_payload,
	output logic [ctqap_pkg::COUNT_W-1:0]            queue_count,
	output logic [ctqap_pkg::LINK_W-1:0]             link_state
);

	localparam int IW = $clog2(QUEUE_SLOTS);
	localparam logic [IW-1:0] LAST = IW'(QUEUE_SLOTS - 1);
	localparam logic [IW:0]   SLOTS_EXT = (IW+1)'(QUEUE_SLOTS);

	function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] i);
		next_slot = (i == LAST) ? '0 : i + IW'(1);
	endfunction

	// slot store and its registered read port
	ctqap_pkg::slot_t slot_mem_q [QUEUE_SLOTS];
	ctqap_pkg::slot_t rd_slot_q;

	// captured item
	logic [ctqap_pkg::ACTION_W-1:0]  in_action_q;
	logic [ctqap_pkg::TIME_W-1:0]    in_now_q;
	logic [ctqap_pkg::ID_W-1:0]      in_id_q;
	logic [ctqap_pkg::LEN_W-1:0]     in_len_q;
	logic [ctqap_pkg::PAYLOAD_W-1:0] in_payload_q;

	// configuration
	logic [ctqap_pkg::TIME_W-1:0] lifetime_q;
	logic [ctqap_pkg::TIME_W-1:0] pacing_gap_q;
	logic                         pacing_en_q;

	// queue and link state
	logic [IW-1:0]                wr_idx_q;
	logic [IW-1:0]                rd_idx_q;
	ctqap_pkg::link_t             link_q;
	logic [ctqap_pkg::TIME_W-1:0] last_issue_q;

	// result register
	logic [ctqap_pkg::STATUS_W-1:0]  out_status_q;
	logic [ctqap_pkg::ID_W-1:0]      out_id_q;
	logic [ctqap_pkg::LEN_W-1:0]     out_len_q;
	logic [ctqap_pkg::PAYLOAD_W-1:0] out_payload_q;
	logic [ctqap_pkg::COUNT_W-1:0]   out_count_q;
	ctqap_pkg::link_t                out_link_q;

	// next values
	logic                            empty;
	logic [ctqap_pkg::LEN_W-1:0]     len_sat;
	logic [ctqap_pkg::TIME_W-1:0]    age;
	logic [ctqap_pkg::TIME_W-1:0]    gap;
	logic [IW-1:0]                   wr_inc;
	logic [IW-1:0]                   rd_inc;
	logic [IW-1:0]                   wr_n;
	logic [IW-1:0]                   rd_n;
	ctqap_pkg::link_t                link_n;
	logic [ctqap_pkg::TIME_W-1:0]    last_issue_n;
	ctqap_pkg::status_t              status_n;
	logic [ctqap_pkg::ID_W-1:0]      id_n;
	logic [ctqap_pkg::LEN_W-1:0]     len_n;
	logic [ctqap_pkg::PAYLOAD_W-1:0] payload_n;
	logic                            mem_we;
	logic [IW:0]                     diff;
	logic [IW+3:0]                   count_ext;

	always_comb begin
		empty        = (wr_idx_q == rd_idx_q);
		len_sat      = (in_len_q > ctqap_pkg::MAX_LEN) ? ctqap_pkg::MAX_LEN : in_len_q;
		age          = in_now_q - rd_slot_q.stamp;
		gap          = in_now_q - last_issue_q;
		wr_inc       = next_slot(wr_idx_q);
		rd_inc       = next_slot(rd_idx_q);
		wr_n         = wr_idx_q;
		rd_n         = rd_idx_q;
		link_n       = link_q;
		last_issue_n = last_issue_q;
		status_n     = ctqap_pkg::ST_NONE;
		id_n         = '0;
		len_n        = '0;
		payload_n    = '0;
		mem_we       = 1'b0;
		case (ctqap_pkg::action_t'(in_action_q))
			ctqap_pkg::ACT_ENQUEUE: begin
				mem_we   = 1'b1;
				wr_n     = wr_inc;
				status_n = ctqap_pkg::ST_QUEUED;
				// full ring: the oldest frame is overwritten
				if (wr_inc == rd_idx_q) begin
					rd_n     = rd_inc;
					status_n = ctqap_pkg::ST_OVERWROTE;
				end
			end
			ctqap_pkg::ACT_POLL: begin
				if (link_q == ctqap_pkg::LINK_SENDING || link_q == ctqap_pkg::LINK_ERROR) begin
					status_n = ctqap_pkg::ST_BLOCKED;
				end else if (empty) begin
					status_n = ctqap_pkg::ST_NONE;
				end else if (age > lifetime_q) begin
					rd_n     = rd_inc;
					status_n = ctqap_pkg::ST_EXPIRED;
				end else if (pacing_en_q && (gap <= pacing_gap_q)) begin
					status_n = ctqap_pkg::ST_PACING;
				end else begin
					last_issue_n = in_now_q;
					id_n         = rd_slot_q.id;
					len_n        = rd_slot_q.len;
					payload_n    = rd_slot_q.payload;
					link_n       = ctqap_pkg::LINK_SENDING;
					status_n     = ctqap_pkg::ST_ISSUED;
				end
			end
			ctqap_pkg::ACT_TX_DONE: begin
				if (!empty) rd_n = rd_inc;
				link_n   = ctqap_pkg::LINK_IDLE;
				status_n = ctqap_pkg::ST_COMPLETED;
			end
			ctqap_pkg::ACT_BUS_ERROR: begin
				link_n = ctqap_pkg::LINK_ERROR;
			end
			ctqap_pkg::ACT_RX_FRAME: begin
				if (link_q == ctqap_pkg::LINK_ERROR) link_n = ctqap_pkg::LINK_IDLE;
			end
			default: begin
			end
		endcase
		// frames held, modulo the ring size
		diff = {1'b0, wr_n} - {1'b0, rd_n};
		if (diff[IW]) diff = diff + SLOTS_EXT;
		count_ext = {4'b0000, diff[IW-1:0]};
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && mem_we) begin
			slot_mem_q[wr_idx_q] <= '{stamp: in_now_q, payload: in_payload_q,
				id: in_id_q, len: len_sat};
		end
		rd_slot_q <= slot_mem_q[rd_idx_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_action_q  <= action;
			in_now_q     <= now_ms;
			in_id_q      <= msg_id;
			in_len_q     <= msg_len;
			in_payload_q <= msg_payload;
		end
		if (cmd.commit) begin
			out_status_q  <= status_n;
			out_id_q      <= id_n;
			out_len_q     <= len_n;
			out_payload_q <= payload_n;
			out_count_q   <= count_ext[3:0];
			out_link_q    <= link_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lifetime_q   <= ctqap_pkg::LIFETIME_RST;
			pacing_gap_q <= ctqap_pkg::PACING_GAP_RST;
			pacing_en_q  <= ctqap_pkg::PACING_EN_RST;
			wr_idx_q     <= '0;
			rd_idx_q     <= '0;
			link_q       <= ctqap_pkg::LINK_IDLE;
			last_issue_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (ctqap_pkg::cfg_idx_t'(cfg_index))
					ctqap_pkg::CFG_LIFETIME:   lifetime_q   <= cfg_data;
					ctqap_pkg::CFG_PACING_GAP: pacing_gap_q <= cfg_data;
					ctqap_pkg::CFG_PACING_EN:  pacing_en_q  <= cfg_data[0];
					default: begin
					end
				endcase
			end
			if (cmd.commit) begin
				wr_idx_q     <= wr_n;
				rd_idx_q     <= rd_n;
				link_q       <= link_n;
				last_issue_q <= last_issue_n;
			end
		end
	end

	assign status        = out_status_q;
	assign frame_id      = out_id_q;
	assign frame_len     = out_len_q;
	assign frame_payload = out_payload_q;
	assign queue_count   = out_count_q;
	assign link_state    = out_link_q;

`ifndef ASSERT_OFF
	a_idx_move_on_commit: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.commit |=> $stable(rd_idx_q) && $stable(wr_idx_q))
		else $error("ring index moved without a commit");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_idx_q <= LAST && wr_idx_q <= LAST)
		else $error("ring index beyond last slot");

	a_frame_zero_unless_issued: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && status_n != ctqap_pkg::ST_ISSUED |=>
		out_id_q == '0 && out_len_q == '0 && out_payload_q == '0)
		else $error("frame fields set without an issue");

	a_issue_enters_sending: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && status_n == ctqap_pkg::ST_ISSUED |=>
		link_q == ctqap_pkg::LINK_SENDING && last_issue_q == $past(in_now_q))
		else $error("issue did not enter sending or stamp the issue time");
`endif

endmodule

`default_nettype wire

// ----- src/can_tx_queue_with_aging_and_pacing_unit.sv -----
// can_tx_queue_with_aging_and_pacing_unit: top level, stream ports and configuration port
// depends on ctqap_pkg, ctqap_ctrl and ctqap_dp
`default_nettype none

// Transmit queue for standard CAN frames held in a ring of QUEUE_SLOTS slots; an
// enqueue into a full ring overwrites the oldest frame, so at most QUEUE_SLOTS-1 are
// held. Each input transfer (enqueue, poll, transmit done, bus error, frame received)
// gives exactly one result transfer. An item is first captured while the head slot is
// read from the slot memory's registered read port, then ages are compared against the
// configuration and the result is committed; a stalled result port holds the commit
// step until the result register is free. A new item is taken while a
// finished result still waits on the master side. Configuration writes take effect at
// once and are meant for idle periods.
module can_tx_queue_with_aging_and_pacing_unit #(
	parameter int QUEUE_SLOTS = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [ctqap_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [ctqap_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire logic                                  s_axis_tvalid,
	output logic                                       s_axis_tready,
	// now_ms[31:0], msg_id[42:32], msg_len[46:43], msg_payload[110:47], zero pad[111]
	input  wire logic [ctqap_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	// action[2:0]
	input  wire logic [ctqap_pkg::ACTION_W-1:0]        s_axis_tuser,
	output logic                                       m_axis_tvalid,
	input  wire logic                                  m_axis_tready,
	// frame_id[10:0], frame_len[14:11], frame_payload[78:15], queue_count[82:79],
	// link_state[84:83], zero pad[87:85]
	output logic [ctqap_pkg::OUT_DATA_W-1:0]           m_axis_tdata,
	// status[2:0]
	output logic [ctqap_pkg::STATUS_W-1:0]             m_axis_tuser
);

	ctqap_pkg::dp_cmd_t cmd;

	logic [ctqap_pkg::ID_W-1:0]      frame_id;
	logic [ctqap_pkg::LEN_W-1:0]     frame_len;
	logic [ctqap_pkg::PAYLOAD_W-1:0] frame_payload;
	logic [ctqap_pkg::COUNT_W-1:0]   queue_count;
	logic [ctqap_pkg::LINK_W-1:0]    link_state;

	ctqap_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	ctqap_dp #(
		.QUEUE_SLOTS (QUEUE_SLOTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.action        (s_axis_tuser),
		.now_ms        (s_axis_tdata[31:0]),
		.msg_id        (s_axis_tdata[42:32]),
		.msg_len       (s_axis_tdata[46:43]),
		.msg_payload   (s_axis_tdata[110:47]),
		.status        (m_axis_tuser),
		.frame_id      (frame_id),
		.frame_len     (frame_len),
		.frame_payload (frame_payload),
		.queue_count   (queue_count),
		.link_state    (link_state)
	);

	assign m_axis_tdata = {3'b000, link_state, queue_count, frame_payload, frame_len,
		frame_id};

endmodule

`default_nettype wire

// ----- test/can_tx_queue_with_aging_and_pacing_unit_test.sv -----
// testbench for can_tx_queue_with_aging_and_pacing_unit: a directed table, then random
// phases under several register settings; results are checked against a behavioral queue
// depends on ctqap_pkg and the top level only
`timescale 1ns / 1ps

module can_tx_queue_with_aging_and_pacing_unit_test;

	localparam int SLOTS          = 16;
	localparam int PHASES         = 6;
	localparam int PHASE_ITEMS    = 155;
	localparam int LONG_HOLD      = 300;
	localparam int TAIL_CYCLES    = 8;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PRINT_LIMIT    = 40;

	localparam logic [ctqap_pkg::CFG_IDX_W-1:0] CFG_SPARE       = 2'd3;
	localparam logic [ctqap_pkg::ACTION_W-1:0]  ACT_SPARE_FIRST = 3'd5;
	localparam logic [ctqap_pkg::ACTION_W-1:0]  ACT_SPARE_LAST  = 3'd7;

	typedef struct packed {
		ctqap_pkg::status_t              status;
		logic [ctqap_pkg::ID_W-1:0]      id;
		logic [ctqap_pkg::LEN_W-1:0]     len;
		logic [ctqap_pkg::PAYLOAD_W-1:0] payload;
		logic [ctqap_pkg::COUNT_W-1:0]   count;
		ctqap_pkg::link_t                link;
	} frame_result_t;

	typedef struct {
		logic [ctqap_pkg::ACTION_W-1:0]  act;
		logic [ctqap_pkg::TIME_W-1:0]    now;
		logic [ctqap_pkg::ID_W-1:0]      id;
		logic [ctqap_pkg::LEN_W-1:0]     len;
		logic [ctqap_pkg::PAYLOAD_W-1:0] payload;
		bit                              typed;
		frame_result_t                   want;
	} drill_row_t;

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_we;
	logic [ctqap_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [ctqap_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                             s_axis_tvalid;
	logic                             s_axis_tready;
	logic [ctqap_pkg::IN_DATA_W-1:0]  s_axis_tdata;
	logic [ctqap_pkg::ACTION_W-1:0]   s_axis_tuser;
	logic                             m_axis_tvalid;
	logic                             m_axis_tready;
	logic [ctqap_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic [ctqap_pkg::STATUS_W-1:0]   m_axis_tuser;

	can_tx_queue_with_aging_and_pacing_unit #(
		.QUEUE_SLOTS(SLOTS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	// behavioral copy of the queue
	logic [ctqap_pkg::ID_W-1:0]      id_store      [SLOTS];
	logic [ctqap_pkg::LEN_W-1:0]     len_store     [SLOTS];
	logic [ctqap_pkg::PAYLOAD_W-1:0] payload_store [SLOTS];
	logic [ctqap_pkg::TIME_W-1:0]    stamp_store   [SLOTS];
	int unsigned                     wr_ptr = 0;
	int unsigned                     rd_ptr = 0;
	ctqap_pkg::link_t                link_now = ctqap_pkg::LINK_IDLE;
	logic [ctqap_pkg::TIME_W-1:0]    last_issue = '0;
	logic [ctqap_pkg::TIME_W-1:0]    lifetime_cfg = ctqap_pkg::LIFETIME_RST;
	logic [ctqap_pkg::TIME_W-1:0]    gap_cfg = ctqap_pkg::PACING_GAP_RST;
	logic                            pacing_on = ctqap_pkg::PACING_EN_RST;

	frame_result_t pending_results [$];
	drill_row_t    drill_rows [$];
	frame_result_t predicted;
	frame_result_t oldest;
	int            accepted_count = 0;
	int            checked_count = 0;
	int            mismatches = 0;
	int            stall_cycles = 0;
	bit            tx_gaps_on = 1'b0;
	bit            rx_gaps_on = 1'b0;
	bit            hold_request = 1'b0;
	logic [ctqap_pkg::TIME_W-1:0] clock_ms;

	function automatic frame_result_t advance_queue(
		input logic [ctqap_pkg::ACTION_W-1:0] act,
		input logic [ctqap_pkg::TIME_W-1:0] now, input logic [ctqap_pkg::ID_W-1:0] id,
		input logic [ctqap_pkg::LEN_W-1:0] len_raw,
		input logic [ctqap_pkg::PAYLOAD_W-1:0] pay);
		frame_result_t r;
		logic [ctqap_pkg::LEN_W-1:0] len;
		logic [ctqap_pkg::TIME_W-1:0] age;
		logic [ctqap_pkg::TIME_W-1:0] since_issue;
		logic was_empty;
		int unsigned held;
		r = '0;
		len = (len_raw > ctqap_pkg::MAX_LEN) ? ctqap_pkg::MAX_LEN : len_raw;
		was_empty = (wr_ptr == rd_ptr);
		case (act)
			ctqap_pkg::ACT_ENQUEUE: begin
				id_store[wr_ptr] = id;
				len_store[wr_ptr] = len;
				payload_store[wr_ptr] = pay;
				stamp_store[wr_ptr] = now;
				wr_ptr = (wr_ptr + 1) % SLOTS;
				r.status = ctqap_pkg::ST_QUEUED;
				if (wr_ptr == rd_ptr) begin
					rd_ptr = (rd_ptr + 1) % SLOTS;
					r.status = ctqap_pkg::ST_OVERWROTE;
				end
			end
			ctqap_pkg::ACT_POLL: begin
				if (link_now != ctqap_pkg::LINK_IDLE) begin
					r.status = ctqap_pkg::ST_BLOCKED;
				end else if (!was_empty) begin
					age = now - stamp_store[rd_ptr];
					since_issue = now - last_issue;
					if (age > lifetime_cfg) begin
						rd_ptr = (rd_ptr + 1) % SLOTS;
						r.status = ctqap_pkg::ST_EXPIRED;
					end else if (pacing_on && since_issue <= gap_cfg) begin
						r.status = ctqap_pkg::ST_PACING;
					end else begin
						last_issue = now;
						r.id = id_store[rd_ptr];
						r.len = len_store[rd_ptr];
						r.payload = payload_store[rd_ptr];
						link_now = ctqap_pkg::LINK_SENDING;
						r.status = ctqap_pkg::ST_ISSUED;
					end
				end
			end
			ctqap_pkg::ACT_TX_DONE: begin
				if (!was_empty)
					rd_ptr = (rd_ptr + 1) % SLOTS;
				link_now = ctqap_pkg::LINK_IDLE;
				r.status = ctqap_pkg::ST_COMPLETED;
			end
			ctqap_pkg::ACT_BUS_ERROR: begin
				link_now = ctqap_pkg::LINK_ERROR;
			end
			ctqap_pkg::ACT_RX_FRAME: begin
				if (link_now == ctqap_pkg::LINK_ERROR)
					link_now = ctqap_pkg::LINK_IDLE;
			end
			default: begin
			end
		endcase
		held = (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : SLOTS - rd_ptr + wr_ptr;
		r.count = ctqap_pkg::COUNT_W'(held);
		r.link = link_now;
		return r;
	endfunction

	function automatic frame_result_t outcome(input ctqap_pkg::status_t st,
		input logic [ctqap_pkg::ID_W-1:0] fid, input logic [ctqap_pkg::LEN_W-1:0] flen,
		input logic [ctqap_pkg::PAYLOAD_W-1:0] fpay,
		input logic [ctqap_pkg::COUNT_W-1:0] cnt, input ctqap_pkg::link_t link);
		return {st, fid, flen, fpay, cnt, link};
	endfunction

	task automatic drill(input bit typed, input logic [ctqap_pkg::ACTION_W-1:0] act,
		input logic [ctqap_pkg::TIME_W-1:0] now, input logic [ctqap_pkg::ID_W-1:0] id,
		input logic [ctqap_pkg::LEN_W-1:0] len,
		input logic [ctqap_pkg::PAYLOAD_W-1:0] pay, input frame_result_t want);
		drill_row_t row;
		row.act = act;
		row.now = now;
		row.id = id;
		row.len = len;
		row.payload = pay;
		row.typed = typed;
		row.want = want;
		drill_rows.push_back(row);
	endtask

	task automatic report_mismatch(input string field, input logic [63:0] got,
		input logic [63:0] want);
		if (mismatches < PRINT_LIMIT)
			$display("mismatch on %s, result %0d at %0t ns: got %h, expected %h",
				field, checked_count, $realtime, got, want);
		mismatches++;
	endtask

	task automatic check_field(input string field, input logic [63:0] got,
		input logic [63:0] want);
		if (got !== want)
			report_mismatch(field, got, want);
	endtask

	function automatic int idle_span();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			return $urandom_range(1, 3);
		if (pick < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_item(input logic [ctqap_pkg::ACTION_W-1:0] act,
		input logic [ctqap_pkg::TIME_W-1:0] now, input logic [ctqap_pkg::ID_W-1:0] id,
		input logic [ctqap_pkg::LEN_W-1:0] len,
		input logic [ctqap_pkg::PAYLOAD_W-1:0] pay);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= act;
		s_axis_tdata <= {1'b0, pay, len, id, now};
		do @(posedge clk); while (!s_axis_tready);
		gap = (tx_gaps_on && $urandom_range(0, 2) == 0) ? idle_span() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// sender stops until every result is back, then lets the pipeline settle
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_config(input logic [ctqap_pkg::TIME_W-1:0] life,
		input logic [ctqap_pkg::TIME_W-1:0] gap,
		input logic [ctqap_pkg::CFG_DATA_W-1:0] en_word);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= ctqap_pkg::CFG_LIFETIME;
		cfg_data <= life;
		@(posedge clk);
		cfg_index <= ctqap_pkg::CFG_PACING_GAP;
		cfg_data <= gap;
		@(posedge clk);
		cfg_index <= ctqap_pkg::CFG_PACING_EN;
		cfg_data <= en_word;
		@(posedge clk);
		cfg_index <= CFG_SPARE;
		cfg_data <= $urandom;
		@(posedge clk);
		cfg_we <= 1'b0;
		lifetime_cfg = life;
		gap_cfg = gap;
		pacing_on = en_word[0];
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (rx_gaps_on && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				repeat (idle_span()) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			predicted = advance_queue(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[42:32],
				s_axis_tdata[46:43], s_axis_tdata[110:47]);
			if (accepted_count < drill_rows.size() && drill_rows[accepted_count].typed)
				predicted = drill_rows[accepted_count].want;
			pending_results.push_back(predicted);
			accepted_count++;
		end
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected transfer", 64'(m_axis_tuser), '0);
			end else begin
				oldest = pending_results.pop_front();
				check_field("status", 64'(m_axis_tuser), 64'(oldest.status));
				check_field("frame_id", 64'(m_axis_tdata[10:0]), 64'(oldest.id));
				check_field("frame_len", 64'(m_axis_tdata[14:11]), 64'(oldest.len));
				check_field("frame_payload", m_axis_tdata[78:15], oldest.payload);
				check_field("queue_count", 64'(m_axis_tdata[82:79]), 64'(oldest.count));
				check_field("link_state", 64'(m_axis_tdata[84:83]), 64'(oldest.link));
			end
			checked_count++;
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int n;
		int pick;
		int enq_pct;
		logic [ctqap_pkg::ACTION_W-1:0] act;

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= ctqap_pkg::CFG_LIFETIME;
		cfg_data <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= ctqap_pkg::ACT_ENQUEUE;

		// reset registers: lifetime 1000, gap 100, pacing on
		drill(1, ctqap_pkg::ACT_POLL, 32'd0, 11'd0, 4'd0, 64'd0,
			outcome(ctqap_pkg::ST_NONE, 11'd0, 4'd0, 64'd0, 4'd0, ctqap_pkg::LINK_IDLE));
		drill(1, ctqap_pkg::ACT_TX_DONE, 32'd0, 11'd0, 4'd0, 64'd0,
			outcome(ctqap_pkg::ST_COMPLETED, 11'd0, 4'd0, 64'd0, 4'd0,
				ctqap_pkg::LINK_IDLE));
		drill(1, ctqap_pkg::ACT_ENQUEUE, 32'd5, 11'h7FF, 4'hF, '1,
			outcome(ctqap_pkg::ST_QUEUED, 11'd0, 4'd0, 64'd0, 4'd1, ctqap_pkg::LINK_IDLE));
		drill(1, ctqap_pkg::ACT_POLL, 32'd50, 11'd0, 4'd0, 64'd0,
			outcome(ctqap_pkg::ST_PACING, 11'd0, 4'd0, 64'd0, 4'd1, ctqap_pkg::LINK_IDLE));
		drill(1, ctqap_pkg::ACT_POLL, 32'd101, 11'd0, 4'd0, 64'd0,
			outcome(ctqap_pkg::ST_ISSUED, 11'h7FF, 4'd8, '1, 4'd1,
				ctqap_pkg::LINK_SENDING));
		drill(1, ctqap_pkg::ACT_POLL, 32'd102, 11'd0, 4'd0, 64'd0,
			outcome(ctqap_pkg::ST_BLOCKED, 11'd0, 4'd0, 64'd0, 4'd1,
				ctqap_pkg::LINK_SENDING));
		drill(1, ctqap_pkg::ACT_ENQUEUE, 32'd103, 11'd0, 4'd0, 64'd0,
			outcome(ctqap_pkg::ST_QUEUED, 11'd0, 4'd0, 64'd0, 4'd2,
				ctqap_pkg::LINK_SENDING));
		drill(1, ctqap_pkg::ACT_TX_DONE, 32'd104, 11'd0, 4'd0, 64'd0,
			outcome(ctqap_pkg::ST_COMPLETED, 11'd0, 4'd0, 64'd0, 4'd1,
				ctqap_pkg::LINK_IDLE));
		drill(1, ctqap_pkg::ACT_BUS_ERROR, 32'd105, 11'd0, 4'd0, 64'd0,
			outcome(ctqap_pkg::ST_NONE, 11'd0, 4'd0, 64'd0, 4'd1, ctqap_pkg::LINK_ERROR));
		drill(1, ctqap_pkg::ACT_POLL, 32'd106, 11'd0, 4'd0, 64'd0,
			outcome(ctqap_pkg::ST_BLOCKED, 11'd0, 4'd0, 64'd0, 4'd1,
				ctqap_pkg::LINK_ERROR));
		drill(1, ctqap_pkg::ACT_ENQUEUE, 32'd107, 11'h155, 4'd9, 64'hA5A5_A5A5_A5A5_A5A5,
			outcome(ctqap_pkg::ST_QUEUED, 11'd0, 4'd0, 64'd0, 4'd2, ctqap_pkg::LINK_ERROR));
		drill(1, ctqap_pkg::ACT_RX_FRAME, 32'd108, 11'd0, 4'd0, 64'd0,
			outcome(ctqap_pkg::ST_NONE, 11'd0, 4'd0, 64'd0, 4'd2, ctqap_pkg::LINK_IDLE));
		drill(1, ctqap_pkg::ACT_RX_FRAME, 32'd109, 11'd0, 4'd0, 64'd0,
			outcome(ctqap_pkg::ST_NONE, 11'd0, 4'd0, 64'd0, 4'd2, ctqap_pkg::LINK_IDLE));
		drill(1, ACT_SPARE_FIRST, 32'd110, 11'h7FF, 4'hF, '1,
			outcome(ctqap_pkg::ST_NONE, 11'd0, 4'd0, 64'd0, 4'd2, ctqap_pkg::LINK_IDLE));
		drill(1, ACT_SPARE_LAST, 32'd110, 11'h7FF, 4'hF, '1,
			outcome(ctqap_pkg::ST_NONE, 11'd0, 4'd0, 64'd0, 4'd2, ctqap_pkg::LINK_IDLE));
		drill(1, ctqap_pkg::ACT_POLL, 32'd2000, 11'd0, 4'd0, 64'd0,
			outcome(ctqap_pkg::ST_EXPIRED, 11'd0, 4'd0, 64'd0, 4'd1,
				ctqap_pkg::LINK_IDLE));
		drill(1, ctqap_pkg::ACT_POLL, 32'd2001, 11'd0, 4'd0, 64'd0,
			outcome(ctqap_pkg::ST_EXPIRED, 11'd0, 4'd0, 64'd0, 4'd0,
				ctqap_pkg::LINK_IDLE));
		drill(1, ctqap_pkg::ACT_ENQUEUE, 32'hFFFF_FFF0, 11'h2AA, 4'd4,
			64'h0123_4567_89AB_CDEF,
			outcome(ctqap_pkg::ST_QUEUED, 11'd0, 4'd0, 64'd0, 4'd1, ctqap_pkg::LINK_IDLE));
		// time wraps between stamp and poll
		drill(0, ctqap_pkg::ACT_POLL, 32'h0000_0010, 11'd0, 4'd0, 64'd0, '0);
		drill(0, ctqap_pkg::ACT_RX_FRAME, 32'h0000_0010, 11'd0, 4'd0, 64'd0, '0);
		drill(1, ctqap_pkg::ACT_TX_DONE, 32'h0000_0011, 11'd0, 4'd0, 64'd0,
			outcome(ctqap_pkg::ST_COMPLETED, 11'd0, 4'd0, 64'd0, 4'd0,
				ctqap_pkg::LINK_IDLE));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (drill_rows[i])
			send_item(drill_rows[i].act, drill_rows[i].now, drill_rows[i].id,
				drill_rows[i].len, drill_rows[i].payload);

		clock_ms = 32'd200;
		for (int phase = 0; phase < PHASES; phase++) begin
			enq_pct = 40;
			case (phase)
				1: begin
					write_config(32'd0, 32'd0, 32'h0000_0001);
					clock_ms = $urandom;
				end
				2: begin
					write_config('1, '1, 32'hFFFF_FFFE);
					clock_ms = 32'hFFFF_FF00;
					enq_pct = 65;
				end
				3: begin
					write_config('1, '1, 32'h0000_0001);
					clock_ms = $urandom;
				end
				4: begin
					write_config($urandom_range(20, 300), $urandom_range(0, 60), $urandom);
					clock_ms = $urandom;
					enq_pct = 45;
				end
				5: begin
					write_config($urandom_range(500, 5000), $urandom_range(0, 200),
						32'h8000_0001);
					clock_ms = $urandom;
					enq_pct = 50;
				end
				default: begin
				end
			endcase
			tx_gaps_on = (phase != 0 && phase != 3);
			rx_gaps_on = (phase != 0 && phase != 2);
			n = 0;
			while (n < PHASE_ITEMS) begin
				if (phase == 4 && n == 40)
					hold_request = 1'b1;
				if (phase == 5 && n == 70)
					wait_idle();
				pick = $urandom_range(0, 99);
				if (pick < 70)
					clock_ms += $urandom_range(0, 20);
				else if (pick < 90)
					clock_ms += $urandom_range(21, 150);
				else if (pick < 97)
					clock_ms += $urandom_range(151, 1500);
				else
					clock_ms += $urandom;
				if ($urandom_range(0, 99) < enq_pct) begin
					act = ctqap_pkg::ACT_ENQUEUE;
				end else begin
					pick = $urandom_range(0, 99);
					if (pick < 50)
						act = ctqap_pkg::ACT_POLL;
					else if (pick < 75)
						act = ctqap_pkg::ACT_TX_DONE;
					else if (pick < 82)
						act = ctqap_pkg::ACT_BUS_ERROR;
					else if (pick < 92)
						act = ctqap_pkg::ACT_RX_FRAME;
					else
						act = ctqap_pkg::ACTION_W'($urandom_range(ACT_SPARE_FIRST,
							ACT_SPARE_LAST));
				end
				send_item(act, clock_ms, ctqap_pkg::ID_W'($urandom_range(0, 2047)),
					ctqap_pkg::LEN_W'($urandom_range(0, 15)), {$urandom, $urandom});
				if (act < ACT_SPARE_FIRST)
					n++;
			end
		end

		wait_idle();
		if (mismatches == 0 && pending_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
